// File: hw/rtl/gwnm_pkg.sv
// Package for the greedy wildcard name matcher: item types, command codes,
// wildcard characters and the ASCII case-fold helper. No dependencies.
`default_nettype none

package gwnm_pkg;

    // Command codes as they arrive on the input channel
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_NAME   = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // Wildcard characters of the filter pattern
    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;

    // Letter range folded to lower case
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register map (byte address bit 2 selects the register)
    localparam int         PADDR_W       = 3;
    localparam logic [0:0] REG_FOLD_CASE = 1'b0;

    // Operation carried from front to back
    typedef enum logic [1:0] {
        OP_APPEND,
        OP_NAME,
        OP_END,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } item_t;

    // Fold an upper-case ASCII letter to lower case when folding is on
    function automatic logic [7:0] fold(input logic fold_case, input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (fold_case && (c >= UPPER_A) && (c <= UPPER_Z)) begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gwnm_front.sv
// Front end of the matcher: decodes commands and drops items without effect.
// Depends on gwnm_pkg for the command codes and the item type.
`default_nettype none

module gwnm_front (
    input  wire logic           in_valid,
    input  wire logic [1:0]     command,
    input  wire logic [7:0]     character,
    input  wire logic           queue_full,
    output logic                in_stall,
    output logic                push,
    output gwnm_pkg::item_t     item
);

    logic keep;

    // Decode the command into an operation
    always_comb
    begin
        item.ch = character;
        unique case (command)
            gwnm_pkg::CMD_APPEND: item.op = gwnm_pkg::OP_APPEND;
            gwnm_pkg::CMD_NAME:   item.op = gwnm_pkg::OP_NAME;
            gwnm_pkg::CMD_END:    item.op = gwnm_pkg::OP_END;
            default:              item.op = gwnm_pkg::OP_CLEAR;
        endcase
    end

    // Drop zero characters: they change nothing
    always_comb
    begin
        keep = 1'b1;
        if (((item.op == gwnm_pkg::OP_APPEND) || (item.op == gwnm_pkg::OP_NAME))
            && (character == 8'h00)) begin
            keep = 1'b0;
        end
    end

    // Hold off the sender while the queue is full
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full && keep;

endmodule

`default_nettype wire

// File: hw/rtl/gwnm_queue.sv
// Short queue that decouples the front end from the back end.
// Depends on gwnm_pkg for the item type and queue sizing.
`default_nettype none

module gwnm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  gwnm_pkg::item_t      push_item,
    input  wire logic            pop,
    output gwnm_pkg::item_t      head,
    output logic                 not_empty,
    output logic                 full
);

    gwnm_pkg::item_t                  ent_reg [gwnm_pkg::QUEUE_DEPTH];
    logic [gwnm_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [gwnm_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [gwnm_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == gwnm_pkg::QCNT_W'(gwnm_pkg::QUEUE_DEPTH));
    assign head      = ent_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == gwnm_pkg::QPTR_W'(gwnm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == gwnm_pkg::QPTR_W'(gwnm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gwnm_back.sv
// Back end of the matcher: pattern memory, greedy match state and result register.
// Depends on gwnm_pkg for the item type, wildcard codes and fold function.
`default_nettype none

module gwnm_back #(
    parameter int PATTERN_DEPTH = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         fold_case,
    input  gwnm_pkg::item_t   head,
    input  wire logic         head_valid,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic              matched
);

    localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int LW = $clog2(PATTERN_DEPTH + 1);
    localparam logic [LW:0] DEPTH_W = (LW + 1)'(PATTERN_DEPTH);

    // Pattern memory: no reset, entries are used only after being written
    logic [7:0] store_mem [PATTERN_DEPTH];

    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic          seek_reg, seek_next;
    logic [7:0]    target_reg, target_next;
    logic          decided_reg, decided_next;
    logic          verdict_reg, verdict_next;
    logic          out_valid_reg, out_valid_next;
    logic          matched_reg, matched_next;

    // Pattern entries at pos and pos+1, registered from the next-position addresses
    logic [7:0]    p_cur_reg, p_nxt_reg;

    logic          wr_en;
    logic [AW-1:0] wr_idx;
    logic [LW:0]   ra0, ra1;
    logic          ra0_ok, ra1_ok;
    logic [AW-1:0] idx0, idx1;
    logic          out_free;
    logic [7:0]    fc, ft, fp, fn;
    logic [LW:0]   pos_plus1;

    // Take the head unless a result would overwrite a waiting one
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = head_valid && ((head.op != gwnm_pkg::OP_END) || out_free);

    assign fc        = gwnm_pkg::fold(fold_case, head.ch);
    assign ft        = gwnm_pkg::fold(fold_case, target_reg);
    assign fp        = gwnm_pkg::fold(fold_case, p_cur_reg);
    assign fn        = gwnm_pkg::fold(fold_case, p_nxt_reg);
    assign pos_plus1 = {1'b0, pos_reg} + 1'b1;

    // Carry out the operation at the head of the queue
    always_comb
    begin
        len_next       = len_reg;
        pos_next       = pos_reg;
        seek_next      = seek_reg;
        target_next    = target_reg;
        decided_next   = decided_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg && out_stall;
        matched_next   = matched_reg;
        wr_en          = 1'b0;
        wr_idx         = len_reg[AW-1:0];

        if (pop) begin
            unique case (head.op)
                gwnm_pkg::OP_APPEND:
                begin
                    if ({1'b0, len_reg} < DEPTH_W) begin
                        wr_en    = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                end
                gwnm_pkg::OP_NAME:
                begin
                    if (decided_reg) begin
                        // outcome fixed: ignore the rest of the name
                    end else if (seek_reg) begin
                        if (fc == ft) begin
                            seek_next = 1'b0;
                        end
                    end else if (pos_reg >= len_reg) begin
                        decided_next = 1'b1;
                        verdict_next = 1'b1;
                    end else if (p_cur_reg == gwnm_pkg::STAR_CHAR) begin
                        if (pos_plus1 >= {1'b0, len_reg}) begin
                            // trailing star matches the rest
                            decided_next = 1'b1;
                            verdict_next = 1'b1;
                        end else begin
                            target_next = p_nxt_reg;
                            pos_next    = pos_reg + LW'(2);
                            if (fc != fn) begin
                                seek_next = 1'b1;
                            end
                        end
                    end else if ((p_cur_reg == gwnm_pkg::ANY_CHAR) || (fp == fc)) begin
                        pos_next = pos_plus1[LW-1:0];
                    end else begin
                        decided_next = 1'b1;
                        verdict_next = 1'b0;
                    end
                end
                gwnm_pkg::OP_END:
                begin
                    out_valid_next = 1'b1;
                    matched_next   = verdict_reg;
                    pos_next       = '0;
                    seek_next      = 1'b0;
                    target_next    = '0;
                    decided_next   = 1'b0;
                    verdict_next   = 1'b1;
                end
                default:
                begin
                    len_next     = '0;
                    pos_next     = '0;
                    seek_next    = 1'b0;
                    target_next  = '0;
                    decided_next = 1'b0;
                    verdict_next = 1'b1;
                end
            endcase
        end
    end

    // Read addresses for the next position, clamped inside the memory
    always_comb
    begin
        ra0    = {1'b0, pos_next};
        ra1    = {1'b0, pos_next} + 1'b1;
        ra0_ok = (ra0 < DEPTH_W);
        ra1_ok = (ra1 < DEPTH_W);
        idx0   = ra0_ok ? ra0[AW-1:0] : '0;
        idx1   = ra1_ok ? ra1[AW-1:0] : '0;
    end

    // Write the pattern memory
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            store_mem[wr_idx] <= head.ch;
        end
    end

    // Read both pattern entries, forwarding a same-cycle append
    always_ff @(posedge clk)
    begin
        if (wr_en && ra0_ok && (wr_idx == idx0)) begin
            p_cur_reg <= head.ch;
        end else begin
            p_cur_reg <= store_mem[idx0];
        end
        if (wr_en && ra1_ok && (wr_idx == idx1)) begin
            p_nxt_reg <= head.ch;
        end else begin
            p_nxt_reg <= store_mem[idx1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_reg       <= '0;
            pos_reg       <= '0;
            seek_reg      <= 1'b0;
            target_reg    <= '0;
            decided_reg   <= 1'b0;
            verdict_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            seek_reg      <= seek_next;
            target_reg    <= target_next;
            decided_reg   <= decided_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule

`default_nettype wire

// File: hw/rtl/greedy_wildcard_name_matcher_unit.sv
// An accepted end-of-name command passes through the queue and then the result
// register; each queued command ahead of it and each stalled result delay it.
// Throughput: one command per cycle unless in_stall; the back end compares against
// two prefetched pattern entries; it retires one command a cycle unless stalled.
// Reset: rst_n clears the pattern length, match state, queue and fold_case;
// the pattern memory is not cleared and its entries are used only after being written.
`default_nettype none

module greedy_wildcard_name_matcher_unit #(
    parameter int PATTERN_DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Item channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    command,
    input  wire logic [7:0]                    character,
    // Result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               matched,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gwnm_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic            fold_case_reg, fold_case_next;
    logic            push, pop, queue_full, queue_ne;
    gwnm_pkg::item_t push_item, head;

    // Configuration register write and read-back
    always_comb
    begin
        fold_case_next = fold_case_reg;
        if (psel && penable && pwrite && (paddr[2] == gwnm_pkg::REG_FOLD_CASE)) begin
            fold_case_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fold_case_reg <= 1'b0;
        end else begin
            fold_case_reg <= fold_case_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == gwnm_pkg::REG_FOLD_CASE) ? {31'd0, fold_case_reg} : 32'd0;

    gwnm_front u_front (
        .in_valid   (in_valid),
        .command    (command),
        .character  (character),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .item       (push_item)
    );

    gwnm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .not_empty (queue_ne),
        .full      (queue_full)
    );

    gwnm_back #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fold_case  (fold_case_reg),
        .head       (head),
        .head_valid (queue_ne),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .matched    (matched)
    );

endmodule

`default_nettype wire
